// ----- sv/ssr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the streaming substring replacer.
// No dependencies; every other file but ssr_if.sv imports this package.
package ssr_pkg;

    // Longest burst one input word can cause (pattern or replacement, at most 8 bytes)
    localparam int BURST_MAX = 8;
    localparam int BIDX_W    = $clog2(BURST_MAX);
    localparam int LEN_W     = 4;

    // Command queue between front and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // APB register map: register i at byte address 8*i
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam logic [2:0] REG_PATTERN_BYTES   = 3'd0;
    localparam logic [2:0] REG_PATTERN_LENGTH  = 3'd1;
    localparam logic [2:0] REG_REPLACE_BYTES   = 3'd2;
    localparam logic [2:0] REG_REPLACE_LENGTH  = 3'd3;
    localparam logic [2:0] REG_INSTANCE_SELECT = 3'd4;

    typedef struct packed {
        logic [63:0]      pattern_bytes;
        logic [LEN_W-1:0] pattern_length;
        logic [63:0]      replace_bytes;
        logic [LEN_W-1:0] replace_length;
        logic [15:0]      instance_select;
    } ssr_cfg_t;

    // One burst of output words; count 0 with last set is a bare end marker
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [LEN_W-1:0]          count;
        logic                      last;
    } ssr_cmd_t;

    // Front end to queue
    typedef struct packed {
        logic     push;
        ssr_cmd_t cmd;
    } ssr_push_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } ssr_qstat_t;

endpackage

// ----- sv/ssr_if.sv -----
`timescale 1ns / 1ps
// Stream channel interfaces of the substring replacer: text in, result out.
// Standalone; valid/ready handshake, a word moves when both are high.
interface ssr_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_last;

    modport source (output valid, output text_byte, output text_last, input ready);
    modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

interface ssr_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;

    modport source (output valid, output out_byte, output out_valid, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_last,
                    output ready);
endinterface

// ----- sv/ssr_cfg_regs.sv -----
`timescale 1ns / 1ps
// APB configuration registers of the substring replacer.
// Depends on ssr_pkg for the register map and the ssr_cfg_t bundle.
module ssr_cfg_regs
    import ssr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output ssr_cfg_t          cfg,
    output logic              pattern_wr
);

    logic [63:0]      pattern_bytes_reg;
    logic [LEN_W-1:0] pattern_length_reg;
    logic [63:0]      replace_bytes_reg;
    logic [LEN_W-1:0] replace_length_reg;
    logic [15:0]      instance_select_reg;
    logic             wr_en;
    logic [2:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];

    // pattern changes drop whatever the window holds
    assign pattern_wr = wr_en &&
                        (reg_idx == REG_PATTERN_BYTES || reg_idx == REG_PATTERN_LENGTH);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg   <= '0;
            pattern_length_reg  <= '0;
            replace_bytes_reg   <= '0;
            replace_length_reg  <= '0;
            instance_select_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PATTERN_BYTES:   pattern_bytes_reg   <= pwdata;
                REG_PATTERN_LENGTH:  pattern_length_reg  <= pwdata[LEN_W-1:0];
                REG_REPLACE_BYTES:   replace_bytes_reg   <= pwdata;
                REG_REPLACE_LENGTH:  replace_length_reg  <= pwdata[LEN_W-1:0];
                REG_INSTANCE_SELECT: instance_select_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read-back
    always_comb
    begin
        case (reg_idx)
            REG_PATTERN_BYTES:   prdata = pattern_bytes_reg;
            REG_PATTERN_LENGTH:  prdata = DATA_W'(pattern_length_reg);
            REG_REPLACE_BYTES:   prdata = replace_bytes_reg;
            REG_REPLACE_LENGTH:  prdata = DATA_W'(replace_length_reg);
            REG_INSTANCE_SELECT: prdata = DATA_W'(instance_select_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.pattern_bytes   = pattern_bytes_reg;
    assign cfg.pattern_length  = pattern_length_reg;
    assign cfg.replace_bytes   = replace_bytes_reg;
    assign cfg.replace_length  = replace_length_reg;
    assign cfg.instance_select = instance_select_reg;

endmodule

// ----- sv/ssr_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts text words, keeps the match window and turns each word
// into at most one output burst command. Depends on ssr_pkg and ssr_text_if.
module ssr_front
    import ssr_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    ssr_text_if.sink    text,
    input  ssr_cfg_t    cfg,
    input  logic        pattern_wr,
    input  ssr_qstat_t  qstat,
    output ssr_push_t   qpush
);

    localparam int W  = PATTERN_MAX;
    localparam int CW = $clog2(W + 1);

    logic [7:0]    win_reg [W];
    logic [7:0]    win_next [W];
    logic [CW-1:0] win_cnt_reg, win_cnt_next;
    logic [15:0]   match_cnt_reg, match_cnt_next;

    logic             accept;
    logic [CW-1:0]    plen, base, cnt1, shift;
    logic [LEN_W-1:0] rlen;
    logic [7:0]       app [W];
    logic [W-1:0]     pre;
    logic             is_match, nth_mode, mc_inc, do_replace;
    ssr_cmd_t         cmd;

    assign text.ready = !qstat.full;
    assign accept     = text.valid && text.ready;

    // saturate configured lengths
    assign plen = (cfg.pattern_length > LEN_W'(PATTERN_MAX)) ? CW'(PATTERN_MAX)
                                                             : CW'(cfg.pattern_length);
    assign rlen = (cfg.replace_length > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX)
                                                             : cfg.replace_length;

    assign base = (win_cnt_reg >= plen) ? '0 : win_cnt_reg;
    assign cnt1 = base + CW'(1);

    // window with the new byte appended
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            app[i] = (CW'(i) == base) ? text.text_byte : win_reg[i];
        end
    end

    // pre[s]: window from position s on is a prefix of the pattern
    always_comb
    begin
        for (int s = 0; s < W; s++)
        begin
            pre[s] = 1'b1;
            for (int j = 0; j < W; j++)
            begin
                if ((s + j < W) && (CW'(s + j) < cnt1) &&
                    (app[(s + j < W) ? s + j : 0] != cfg.pattern_bytes[8*j +: 8]))
                begin
                    pre[s] = 1'b0;
                end
            end
        end
    end

    // fewest leading bytes to release so the rest still starts a match
    always_comb
    begin
        shift = cnt1;
        for (int s = W - 1; s >= 0; s--)
        begin
            if ((CW'(s) < cnt1) && pre[s])
            begin
                shift = CW'(s);
            end
        end
    end

    // window after releasing the leading bytes
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            win_next[i] = app[i];
            for (int k = 0; k < W; k++)
            begin
                if ((CW'(k) == shift) && (i + k < W))
                begin
                    win_next[i] = app[(i + k < W) ? i + k : 0];
                end
            end
        end
    end

    // occurrence selection
    assign is_match   = (cnt1 == plen) && pre[0];
    assign nth_mode   = (cfg.instance_select != '0);
    assign mc_inc     = nth_mode && (match_cnt_reg < cfg.instance_select);
    assign do_replace = !nth_mode || (mc_inc && (match_cnt_reg + 16'd1 == cfg.instance_select));

    // burst command and next state
    always_comb
    begin
        cmd            = '0;
        win_cnt_next   = win_cnt_reg;
        match_cnt_next = match_cnt_reg;
        for (int i = 0; i < BURST_MAX; i++)
        begin
            cmd.bytes[i] = (i < W) ? app[(i < W) ? i : 0] : 8'h00;
        end

        priority if (plen == '0)
        begin
            cmd.bytes[0] = text.text_byte;
            cmd.count    = LEN_W'(1);
            win_cnt_next = '0;
        end
        else if (is_match)
        begin
            if (do_replace)
            begin
                cmd.bytes = cfg.replace_bytes;
                cmd.count = rlen;
            end
            else
            begin
                cmd.count = LEN_W'(plen);
            end
            if (mc_inc)
            begin
                match_cnt_next = match_cnt_reg + 16'd1;
            end
            win_cnt_next = '0;
        end
        else if (text.text_last)
        begin
            cmd.count    = LEN_W'(cnt1);
            win_cnt_next = '0;
        end
        else
        begin
            cmd.count    = LEN_W'(shift);
            win_cnt_next = cnt1 - shift;
        end

        // end of text flushes and restarts counting
        if (text.text_last)
        begin
            cmd.last       = 1'b1;
            win_cnt_next   = '0;
            match_cnt_next = '0;
        end
    end

    assign qpush.cmd  = cmd;
    assign qpush.push = accept && (cmd.last || (cmd.count != '0));

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_cnt_reg   <= '0;
            match_cnt_reg <= '0;
        end
        else if (pattern_wr)
        begin
            win_cnt_reg <= '0;
        end
        else if (accept)
        begin
            win_cnt_reg   <= win_cnt_next;
            match_cnt_reg <= match_cnt_next;
        end
    end

    // window bytes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < W; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule

// ----- sv/ssr_queue.sv -----
`timescale 1ns / 1ps
// Small command queue that decouples the front end from the back end.
// Depends on ssr_pkg for the command type and queue sizing.
module ssr_queue
    import ssr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ssr_push_t  qpush,
    input  logic       pop,
    output ssr_cmd_t   head,
    output ssr_qstat_t qstat
);

    ssr_cmd_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg;
    logic               do_push, do_pop;

    assign qstat.full  = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign qstat.empty = (fill_reg == '0);
    assign do_push     = qpush.push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + QFILL_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - QFILL_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= qpush.cmd;
        end
    end

endmodule

// ----- sv/ssr_back.sv -----
`timescale 1ns / 1ps
// Back end: plays each queued burst out one result word per cycle while
// the sink is ready, via an output register. Uses ssr_pkg, ssr_result_if.
module ssr_back
    import ssr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ssr_cmd_t     head,
    input  ssr_qstat_t   qstat,
    output logic         pop,
    ssr_result_if.source result
);

    logic              ovalid_reg;
    logic [7:0]        obyte_reg;
    logic              oflag_reg;
    logic              olast_reg;
    logic [BIDX_W-1:0] idx_reg;
    logic              load, cmd_done;

    assign load     = !qstat.empty && (!ovalid_reg || result.ready);
    assign cmd_done = (head.count == '0) || (LEN_W'(idx_reg) + LEN_W'(1) == head.count);
    assign pop      = load && cmd_done;

    // output register valid and byte index within the burst
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else if (load)
        begin
            ovalid_reg <= 1'b1;
            idx_reg    <= cmd_done ? '0 : idx_reg + BIDX_W'(1);
        end
        else if (result.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    // output payload; an empty burst gives the bare end marker
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            obyte_reg <= (head.count == '0) ? 8'h00 : head.bytes[idx_reg];
            oflag_reg <= (head.count != '0);
            olast_reg <= head.last && cmd_done;
        end
    end

    assign result.valid     = ovalid_reg;
    assign result.out_byte  = obyte_reg;
    assign result.out_valid = oflag_reg;
    assign result.out_last  = olast_reg;

endmodule

// ----- sv/stream_substring_replace.sv -----
`timescale 1ns / 1ps
// Streaming find-and-replace. Text words are accepted at up to one per cycle
// whenever the 4-entry command queue has room; the front end compares the
// whole window against the pattern combinationally and queues a burst of 0
// to 8 result words, which the back end sends one per cycle while the result
// sink is ready. Sustained rate is therefore one text word per cycle until
// bursts (replacements, releases of held bytes, end-of-text flushes) outpace
// the one-word-per-cycle output register. The first result word of a text
// word passes through the command queue, then the output register; there is
// no clearing pass after reset. Depends on ssr_pkg, ssr_if, ssr_* submodules.
module stream_substring_replace
    import ssr_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    ssr_text_if.sink          text,
    ssr_result_if.source      result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    ssr_cfg_t   cfg;
    logic       pattern_wr;
    ssr_push_t  qpush;
    ssr_qstat_t qstat;
    ssr_cmd_t   head;
    logic       pop;

    ssr_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .pattern_wr (pattern_wr)
    );

    ssr_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .cfg        (cfg),
        .pattern_wr (pattern_wr),
        .qstat      (qstat),
        .qpush      (qpush)
    );

    ssr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .qpush (qpush),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    ssr_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .result (result)
    );

    // front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(qpush.push && qstat.full))
        else $error("command pushed into full queue");

    // end of text always leaves a command waiting
    a_last_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.ready && text.text_last) |=> !qstat.empty)
        else $error("end of text produced no queued command");

    // a word without a byte is only the end marker, with a zero byte
    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.out_valid) |-> (result.out_last && result.out_byte == 8'h00))
        else $error("bare word is not a clean end marker");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for stream_substring_replace: a directed table, then random texts,
// every result word checked against a behavioral find-and-replace predictor, or the typed result of a typed row.
// Depends on ssr_pkg, ssr_if and the RTL of the block.
module tb;
    import ssr_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int PAT_MAX     = 8;
    localparam int REP_MAX     = 8;
    localparam int DRAIN_WAIT  = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TEXT_TARGET = 350;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [7:0] value;
        logic       carries;
        logic       last;
    } out_word_t;

    typedef enum logic {ROW_TEXT, ROW_REG} row_kind_t;

    // One directed step: a register write or a text word, optionally with its result typed in
    typedef struct {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [63:0] val;
        logic        last;
        logic        typed;
        out_word_t   want;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    ssr_text_if   text_ch();
    ssr_result_if res_ch();

    stream_substring_replace #(
        .PATTERN_MAX(PAT_MAX),
        .REPLACE_MAX(REP_MAX)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF clk = ~clk;

    // Predictor copy of the registers and of the match window
    logic [63:0] pat_bytes = '0;
    logic [3:0]  pat_len   = '0;
    logic [63:0] rep_bytes = '0;
    logic [3:0]  rep_len   = '0;
    logic [15:0] nth       = '0;
    logic [7:0]  win [PAT_MAX];
    int          win_n     = 0;
    logic [15:0] hits      = '0;

    out_word_t pending_out[$];
    out_word_t step_out[$];
    row_t      rows[$];

    int mismatches = 0;
    int words_sent = 0;
    int words_seen = 0;
    int rand_words = 0;
    int rand_texts = 0;
    int cycles     = 0;
    int sink_wait  = 0;
    bit text_calm  = 1'b0;
    bit sink_calm  = 1'b0;

    function automatic void report_miss(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic bit held_is_prefix();
        for (int i = 0; i < win_n; i++)
            if (win[i] !== pat_bytes[8*i +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void put_word(logic [7:0] v, logic c);
        out_word_t w;
        w = '{v, c, 1'b0};
        if (step_out.size() < BURST_MAX)
            step_out.push_back(w);
    endfunction

    // Words that one text word releases; updates window, occurrence count
    function automatic void substitute(logic [7:0] b, logic last);
        int plen;
        int rlen;
        bit swap;
        step_out.delete();
        plen = (pat_len > PAT_MAX) ? PAT_MAX : int'(pat_len);
        rlen = (rep_len > REP_MAX) ? REP_MAX : int'(rep_len);
        if (plen == 0) begin
            win_n = 0;
            put_word(b, 1'b1);
        end else begin
            if (win_n >= plen)
                win_n = 0;
            win[win_n] = b;
            win_n++;
            if (win_n == plen && held_is_prefix()) begin
                if (nth == 0) begin
                    swap = 1'b1;
                end else if (hits < nth) begin
                    hits++;
                    swap = (hits == nth);
                end else begin
                    swap = 1'b0;
                end
                if (swap)
                    for (int i = 0; i < rlen; i++) put_word(rep_bytes[8*i +: 8], 1'b1);
                else
                    for (int i = 0; i < plen; i++) put_word(win[i], 1'b1);
                win_n = 0;
            end else begin
                // release leading bytes until the window is a prefix again
                while (win_n > 0 && !held_is_prefix()) begin
                    put_word(win[0], 1'b1);
                    for (int i = 0; i < PAT_MAX - 1; i++) win[i] = win[i+1];
                    win_n--;
                end
            end
        end
        // end of text: flush, reset counters, bare marker if nothing went out
        if (last) begin
            for (int i = 0; i < win_n; i++) put_word(win[i], 1'b1);
            win_n = 0;
            hits  = '0;
            if (step_out.size() == 0)
                put_word(8'h00, 1'b0);
            step_out[step_out.size()-1].last = 1'b1;
        end
    endfunction

    task automatic send_text(logic [7:0] b, logic last);
        int gap;
        gap = text_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.text_last <= last;
        do @(posedge clk); while (!text_ch.ready);
        words_sent++;
    endtask

    task automatic feed(logic [7:0] b, logic last);
        substitute(b, last);
        foreach (step_out[i]) pending_out.push_back(step_out[i]);
        send_text(b, last);
    endtask

    // Register write once the block has drained
    task automatic set_reg(logic [2:0] idx, logic [63:0] val);
        text_ch.valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PATTERN_BYTES:   begin pat_bytes = val; win_n = 0; end
            REG_PATTERN_LENGTH:  begin pat_len = val[3:0]; win_n = 0; end
            REG_REPLACE_BYTES:   rep_bytes = val;
            REG_REPLACE_LENGTH:  rep_len = val[3:0];
            REG_INSTANCE_SELECT: nth = val[15:0];
            default: ;
        endcase
    endtask

    function automatic void add_reg(logic [2:0] idx, logic [63:0] val);
        row_t r;
        r = '{ROW_REG, idx, val, 1'b0, 1'b0, '0};
        rows.push_back(r);
    endfunction

    function automatic void add_text(logic [7:0] b, logic last);
        row_t r;
        r = '{ROW_TEXT, '0, {56'h0, b}, last, 1'b0, '0};
        rows.push_back(r);
    endfunction

    function automatic void add_typed(logic [7:0] b, logic last, out_word_t want);
        row_t r;
        r = '{ROW_TEXT, '0, {56'h0, b}, last, 1'b1, want};
        rows.push_back(r);
    endfunction

    // Result sink: check each word, then draw a stall for the next one
    always @(posedge clk) begin
        out_word_t got;
        out_word_t want;
        if (res_ch.valid && res_ch.ready) begin
            got = '{res_ch.out_byte, res_ch.out_valid, res_ch.out_last};
            words_seen++;
            if (pending_out.size() == 0) begin
                report_miss($sformatf("unexpected word byte=%h valid=%b last=%b",
                                      got.value, got.carries, got.last));
            end else begin
                want = pending_out.pop_front();
                if (got.value !== want.value || got.carries !== want.carries ||
                    got.last !== want.last)
                    report_miss($sformatf("byte %h/%h valid %b/%b last %b/%b (exp/act)",
                                          want.value, got.value, want.carries, got.carries,
                                          want.last, got.last));
            end
            sink_wait = sink_calm ? 0 : $urandom_range(0, 16);
        end else if (sink_wait > 0) begin
            sink_wait--;
        end
        res_ch.ready <= (sink_wait == 0);
    end

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [7:0]  alpha [3];
        logic [63:0] pat;
        int          plen_w;
        int          plen_e;
        int          rlen_w;
        int          tlen;
        int          r;
        int          n;
        logic [15:0] inst;
        logic [7:0]  txt[$];

        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        text_ch.valid     <= 1'b0;
        text_ch.text_byte <= '0;
        text_ch.text_last <= 1'b0;

        // pass-through straight after reset
        add_typed(8'h00, 1'b0, '{8'h00, 1'b1, 1'b0});
        add_typed(8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1});
        // "ab" -> "XYZ", every occurrence, incl. a false start "aab"
        add_reg(REG_PATTERN_BYTES,   64'h6261);
        add_reg(REG_PATTERN_LENGTH,  64'd2);
        add_reg(REG_REPLACE_BYTES,   64'h5A5958);
        add_reg(REG_REPLACE_LENGTH,  64'd3);
        add_reg(REG_INSTANCE_SELECT, 64'd0);
        add_text(8'h78, 1'b0);
        add_text(8'h61, 1'b0);
        add_text(8'h62, 1'b0);
        add_text(8'h61, 1'b0);
        add_text(8'h61, 1'b0);
        add_text(8'h62, 1'b1);
        // empty replacement eats the whole text: bare end marker
        add_reg(REG_PATTERN_LENGTH,  64'd1);
        add_reg(REG_REPLACE_LENGTH,  64'd0);
        add_typed(8'h61, 1'b1, '{8'h00, 1'b0, 1'b1});
        // oversized lengths saturate; all-ones pattern; top occurrence select
        add_reg(REG_PATTERN_BYTES,   '1);
        add_reg(REG_PATTERN_LENGTH,  64'd15);
        add_reg(REG_REPLACE_BYTES,   64'h0807060504030201);
        add_reg(REG_REPLACE_LENGTH,  64'd15);
        add_reg(REG_INSTANCE_SELECT, 64'hFFFF);
        for (int i = 0; i < PAT_MAX; i++) add_text(8'hFF, 1'b0);
        add_text(8'h00, 1'b1);
        // only the second occurrence is replaced
        add_reg(REG_PATTERN_BYTES,   64'h61);
        add_reg(REG_PATTERN_LENGTH,  64'd1);
        add_reg(REG_REPLACE_BYTES,   64'h51);
        add_reg(REG_REPLACE_LENGTH,  64'd1);
        add_reg(REG_INSTANCE_SELECT, 64'd2);
        add_text(8'h61, 1'b0);
        add_text(8'h61, 1'b0);
        add_text(8'h61, 1'b1);
        // pattern rewrite mid-text drops the held byte
        add_reg(REG_PATTERN_BYTES,   64'h6261);
        add_reg(REG_PATTERN_LENGTH,  64'd2);
        add_text(8'h61, 1'b0);
        add_reg(REG_PATTERN_LENGTH,  64'd2);
        add_text(8'h62, 1'b1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_REG) begin
                set_reg(rows[i].idx, rows[i].val);
            end else if (rows[i].typed) begin
                substitute(rows[i].val[7:0], rows[i].last);
                pending_out.push_back(rows[i].want);
                send_text(rows[i].val[7:0], rows[i].last);
            end else begin
                feed(rows[i].val[7:0], rows[i].last);
            end
        end

        // random texts, each under a fresh register setting
        while (rand_words < TEXT_TARGET) begin
            text_calm = ($urandom_range(0, 4) == 0);
            sink_calm = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < 3; k++) alpha[k] = 8'($urandom_range(0, 255));

            r = $urandom_range(0, 9);
            plen_w = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15) :
                     (r == 2) ? PAT_MAX : $urandom_range(1, 4);
            plen_e = (plen_w > PAT_MAX) ? PAT_MAX : plen_w;
            pat = {$urandom, $urandom};
            for (int k = 0; k < plen_e; k++) pat[8*k +: 8] = alpha[$urandom_range(0, 2)];

            r = $urandom_range(0, 9);
            rlen_w = (r == 0) ? 0 : (r == 1) ? 15 : (r == 2) ? REP_MAX : $urandom_range(1, 5);

            r = $urandom_range(0, 9);
            inst = (r < 6) ? 16'd0 : (r < 8) ? 16'($urandom_range(1, 3)) :
                   (r == 8) ? 16'hFFFF : 16'($urandom_range(0, 65535));

            set_reg(REG_PATTERN_BYTES,   pat);
            set_reg(REG_PATTERN_LENGTH,  64'(plen_w));
            set_reg(REG_REPLACE_BYTES,   {$urandom, $urandom});
            set_reg(REG_REPLACE_LENGTH,  64'(rlen_w));
            set_reg(REG_INSTANCE_SELECT, 64'(inst));

            // text mostly built from the pattern, its prefixes and its alphabet
            tlen = $urandom_range(1, 24);
            txt.delete();
            while (txt.size() < tlen) begin
                r = $urandom_range(0, 9);
                if (r < 4) begin
                    for (int k = 0; k < plen_e; k++) txt.push_back(pat[8*k +: 8]);
                end else if (r < 6) begin
                    n = (plen_e > 1) ? $urandom_range(1, plen_e - 1) : plen_e;
                    for (int k = 0; k < n; k++) txt.push_back(pat[8*k +: 8]);
                end else if (r < 9) begin
                    txt.push_back(alpha[$urandom_range(0, 2)]);
                end else begin
                    txt.push_back(8'($urandom_range(0, 255)));
                end
            end
            while (txt.size() > tlen) void'(txt.pop_back());

            foreach (txt[k]) begin
                feed(txt[k], k == txt.size() - 1);
                rand_words++;
            end
            rand_texts++;
        end

        // drain
        text_ch.valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Fed %0d text words (%0d random over %0d random texts), checked %0d results",
                 words_sent, rand_words, rand_texts, words_seen);
        $display("Mismatched or unexpected result words: %0d", mismatches);
        if (mismatches == 0 && pending_out.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
